[rtl/core/kotp_pkg.sv]
`timescale 1ns / 1ps

package kotp_pkg;

	// Field widths.
	localparam int unsigned BCD_W  = 7;
	localparam int unsigned SECS_W = 7;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned LAG_W  = 31;
	localparam int unsigned CODE_W = 14;

	// Generator constants.
	localparam logic [WORD_W-1:0] WEYL_STEP = 32'd1411392427;

	// Reset values. The Weyl register holds the count already advanced by one
	// step, so that its increment stays out of the result path.
	localparam logic [WORD_W-1:0] WEYL_AHEAD_INIT = 32'd123456789 + WEYL_STEP;
	localparam logic [WORD_W-1:0] SHIFT_INIT      = 32'd234567891;
	localparam logic [LAG_W-1:0]  LAG_OLDER_INIT  = 31'd345678912;
	localparam logic [LAG_W-1:0]  LAG_NEWER_INIT  = 31'd456789123;

	// Code range: residue modulo CODE_SPAN, then offset by CODE_MIN.
	localparam logic [CODE_W-1:0] CODE_MIN  = 14'd1001;
	localparam logic [CODE_W-1:0] CODE_MAX  = 14'd9999;
	localparam logic [CODE_W-1:0] CODE_SPAN = CODE_MAX + 14'd1 - CODE_MIN;

	// Reciprocal for the modulo: floor(2^45 / 8999). The estimated quotient
	// is at most one below the true quotient for any 32-bit word.
	localparam int unsigned       RECIP_SHIFT = 45;
	localparam logic [WORD_W-1:0] RECIP_MULT  = 32'd3909809099;
	localparam int unsigned       QUOT_W      = 2 * WORD_W - RECIP_SHIFT;

	// Residue before correction lies below twice the span.
	localparam int unsigned REM_W = CODE_W + 1;

	// Load enables of the two reduction stages.
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} kotp_stage_en_t;

	// Two BCD digits to binary; an out-of-range low digit is taken as it is.
	function automatic logic [SECS_W-1:0] bcd_to_bin(input logic [BCD_W-1:0] bcd);
		logic [SECS_W-1:0] hi;
		logic [SECS_W-1:0] lo;
		hi = {4'b0000, bcd[6:4]};
		lo = {3'b000, bcd[3:0]};
		return (hi << 3) + (hi << 1) + lo;
	endfunction

endpackage

[rtl/core/kotp_generator.sv]
`timescale 1ns / 1ps

module kotp_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [kotp_pkg::BCD_W-1:0]       clock_seconds_bcd,
	output logic [kotp_pkg::WORD_W-1:0]      sum_word
);

	logic [kotp_pkg::WORD_W-1:0] weyl_ahead_q;
	logic [kotp_pkg::WORD_W-1:0] shift_q;
	logic [kotp_pkg::LAG_W-1:0]  lag_older_q;
	logic [kotp_pkg::LAG_W-1:0]  lag_newer_q;
	logic                        carry_q;

	logic [kotp_pkg::WORD_W-1:0] xs_a;
	logic [kotp_pkg::WORD_W-1:0] xs_b;
	logic [kotp_pkg::WORD_W-1:0] xs_next;
	logic [kotp_pkg::WORD_W-1:0] awc_sum;
	logic [kotp_pkg::SECS_W-1:0] secs;

	// Xorshift step with logical shifts.
	always_comb begin
		xs_a    = shift_q ^ (shift_q << 5);
		xs_b    = xs_a ^ (xs_a >> 7);
		xs_next = xs_b ^ (xs_b << 22);
	end

	// Add-with-carry step; bit 31 becomes the new carry.
	assign awc_sum = {1'b0, lag_older_q} + {1'b0, lag_newer_q}
		+ {{(kotp_pkg::WORD_W-1){1'b0}}, carry_q};

	assign secs = kotp_pkg::bcd_to_bin(clock_seconds_bcd);

	// Output word of this step, from the advanced state and the seconds.
	assign sum_word = weyl_ahead_q + xs_next
		+ {1'b0, awc_sum[kotp_pkg::LAG_W-1:0]}
		+ {{(kotp_pkg::WORD_W-kotp_pkg::SECS_W){1'b0}}, secs};

	// Generator state advances once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weyl_ahead_q <= kotp_pkg::WEYL_AHEAD_INIT;
			shift_q      <= kotp_pkg::SHIFT_INIT;
			lag_older_q  <= kotp_pkg::LAG_OLDER_INIT;
			lag_newer_q  <= kotp_pkg::LAG_NEWER_INIT;
			carry_q      <= 1'b0;
		end else if (step) begin
			weyl_ahead_q <= weyl_ahead_q + kotp_pkg::WEYL_STEP;
			shift_q      <= xs_next;
			lag_older_q  <= lag_newer_q;
			lag_newer_q  <= awc_sum[kotp_pkg::LAG_W-1:0];
			carry_q      <= awc_sum[kotp_pkg::WORD_W-1];
		end
	end

endmodule

[rtl/core/kotp_mod_reduce.sv]
`timescale 1ns / 1ps

module kotp_mod_reduce (
	input  logic                            clk,
	input  kotp_pkg::kotp_stage_en_t        en,
	input  logic [kotp_pkg::WORD_W-1:0]     word_s1,
	output logic [kotp_pkg::WORD_W-1:0]     word_s3,
	output logic [kotp_pkg::CODE_W-1:0]     code_s3
);

	logic [2*kotp_pkg::WORD_W-1:0] prod;
	logic [kotp_pkg::QUOT_W-1:0]   quot_s2;
	logic [kotp_pkg::WORD_W-1:0]   word_s2;
	logic [kotp_pkg::WORD_W-1:0]   back_mul;
	logic [kotp_pkg::WORD_W-1:0]   diff;
	logic [kotp_pkg::REM_W-1:0]    rem_raw;
	logic [kotp_pkg::REM_W-1:0]    rem_fix;
	logic [kotp_pkg::CODE_W-1:0]   code_next;

	// Quotient estimate by multiplying with the reciprocal.
	assign prod = {{kotp_pkg::WORD_W{1'b0}}, word_s1}
		* {{kotp_pkg::WORD_W{1'b0}}, kotp_pkg::RECIP_MULT};

	always_ff @(posedge clk) begin
		if (en.load_s2) begin
			quot_s2 <= prod[2*kotp_pkg::WORD_W-1:kotp_pkg::RECIP_SHIFT];
			word_s2 <= word_s1;
		end
	end

	// Residue, with one correction since the estimate may be one short.
	always_comb begin
		back_mul = {{(kotp_pkg::WORD_W-kotp_pkg::QUOT_W){1'b0}}, quot_s2}
			* {{(kotp_pkg::WORD_W-kotp_pkg::CODE_W){1'b0}}, kotp_pkg::CODE_SPAN};
		diff    = word_s2 - back_mul;
		rem_raw = diff[kotp_pkg::REM_W-1:0];
		if (rem_raw >= {1'b0, kotp_pkg::CODE_SPAN}) begin
			rem_fix = rem_raw - {1'b0, kotp_pkg::CODE_SPAN};
		end else begin
			rem_fix = rem_raw;
		end
		code_next = rem_fix[kotp_pkg::CODE_W-1:0] + kotp_pkg::CODE_MIN;
	end

	always_ff @(posedge clk) begin
		if (en.load_s3) begin
			word_s3 <= word_s2;
			code_s3 <= code_next;
		end
	end

endmodule

[rtl/core/kiss_otp_code_generator.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_stall  | clock_seconds_bcd[6:0]
// out     | output    | out_valid, out_stall| random_word[31:0], otp_code[13:0]
//
// One request per cycle is accepted while in_stall is low. Each result
// passes s1, s2 and s3, reciprocal multiply and back-multiply in between.
// The generator state advances in the cycle a request is accepted.
// Reset is asynchronous and active low; it clears the stage valid bits and
// restores the generator seeds.
// A stall on the output holds the result; stages behind it keep filling
// until the pipeline is full, after which in_stall is raised.

module kiss_otp_code_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kotp_pkg::BCD_W-1:0]      clock_seconds_bcd,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kotp_pkg::WORD_W-1:0]     random_word,
	output logic [kotp_pkg::CODE_W-1:0]     otp_code
);

	logic                        valid_s1;
	logic                        valid_s2;
	logic                        valid_s3;
	logic                        ready_s1;
	logic                        ready_s2;
	logic                        ready_s3;
	logic                        in_take;
	logic [kotp_pkg::WORD_W-1:0] sum_word;
	logic [kotp_pkg::WORD_W-1:0] word_s1;
	kotp_pkg::kotp_stage_en_t    stage_en;

	// A stage can load when it is empty or its contents move on.
	assign ready_s3 = !valid_s3 || !out_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign in_take  = in_valid && ready_s1;

	assign stage_en.load_s2 = ready_s2;
	assign stage_en.load_s3 = ready_s3;

	// Generator state and the sum for the incoming request.
	kotp_generator u_generator (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (in_take),
		.clock_seconds_bcd (clock_seconds_bcd),
		.sum_word          (sum_word)
	);

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			word_s1 <= sum_word;
		end
	end

	// Modulo reduction to the four-digit code.
	kotp_mod_reduce u_mod_reduce (
		.clk     (clk),
		.en      (stage_en),
		.word_s1 (word_s1),
		.word_s3 (random_word),
		.code_s3 (otp_code)
	);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign out_valid = valid_s3;

`ifndef NO_ASSERTIONS
	// A delivered code always lies in the four-digit range.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (otp_code >= kotp_pkg::CODE_MIN) && (otp_code <= kotp_pkg::CODE_MAX))
		else $error("otp_code outside 1001..9999");

	// Input is held off only when every stage is occupied and the output stalls.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && out_stall)
		else $error("in_stall raised with a free stage");

	// An accepted request occupies the first stage in the next cycle.
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request lost at first stage");
`endif

endmodule
